@@ rtl/rnc_pkg.sv @@
// Shared types, constants and fp16/fp32 helper functions for the chunked
// RMS normalization block. No dependencies.
package rnc_pkg;

    localparam int MAX_CHUNK = 64;
    localparam int ADDR_W    = $clog2(MAX_CHUNK);
    localparam int LEN_W     = $clog2(MAX_CHUNK + 1);
    localparam int CFG_W     = 32;

    localparam logic [LEN_W-1:0] CHUNK_LEN_RST = LEN_W'(MAX_CHUNK);
    localparam logic [31:0]      EPS_RST       = 32'h358637BD;

    localparam logic [31:0] F32_ONE  = 32'h3F800000;
    localparam logic [31:0] F32_QNAN = 32'h7FC00000;
    localparam logic [31:0] F32_DNAN = 32'hFFC00000;
    localparam logic [31:0] F32_PINF = 32'h7F800000;
    localparam logic [31:0] F32_QBIT = 32'h00400000;
    localparam logic [14:0] F16_QNAN = 15'h7E00;
    localparam logic [14:0] F16_INF  = 15'h7C00;

    typedef enum logic {
        CFG_CHUNK_LEN = 1'b0,
        CFG_EPSILON   = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } fp_req_t;

    typedef struct packed {
        logic        start;
        logic        op_sqrt;
        logic [31:0] a;
        logic [31:0] b;
    } ds_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } fp_rsp_t;

    function automatic logic f32_is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    function automatic logic f32_is_inf(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    endfunction

    function automatic logic f32_is_zero(input logic [31:0] f);
        return f[30:0] == 31'd0;
    endfunction

    // fp16 -> fp32, exact
    function automatic logic [31:0] h2f(input logic [15:0] h);
        logic [4:0]  e5;
        logic [9:0]  m;
        logic [3:0]  p;
        logic [10:0] t;
        logic [7:0]  ef;
        logic [31:0] r;
        e5 = h[14:10];
        m  = h[9:0];
        p  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) p = 4'(i);
        end
        t  = {1'b0, m} << (4'd10 - p);
        ef = 8'(p) + 8'd103;
        if (e5 == 5'h1F) begin
            r = {h[15], 8'hFF, m, 13'd0};
        end else if (e5 == 5'd0) begin
            if (m == 10'd0) r = {h[15], 31'd0};
            else            r = {h[15], ef, t[9:0], 13'd0};
        end else begin
            r = {h[15], 8'(e5) + 8'd112, m, 13'd0};
        end
        return r;
    endfunction

    // fp32 -> fp16, round to nearest even
    function automatic logic [15:0] f2h(input logic [31:0] b);
        logic              s;
        logic [7:0]        ef;
        logic [22:0]       mant;
        logic signed [9:0] e;
        logic [15:0]       hm;
        logic [12:0]       low13;
        logic [23:0]       full;
        logic [4:0]        sh;
        logic [23:0]       hm24;
        logic [23:0]       low24;
        logic [23:0]       half24;
        logic [15:0]       r;
        s    = b[31];
        ef   = b[30:23];
        mant = b[22:0];
        e    = $signed({2'b00, ef}) - 10'sd127;
        hm   = 16'd0;
        if (ef == 8'hFF) begin
            r = {s, (mant != 23'd0) ? F16_QNAN : F16_INF};
        end else if (ef == 8'd0 || e < -10'sd25) begin
            r = {s, 15'd0};
        end else if (e > 10'sd15) begin
            r = {s, F16_INF};
        end else if (e >= -10'sd14) begin
            hm    = {1'b0, 5'(e + 10'sd15), mant[22:13]};
            low13 = mant[12:0];
            if (low13 > 13'h1000 || (low13 == 13'h1000 && hm[0])) hm = hm + 16'd1;
            r = {s, hm[14:0]};
        end else begin
            full   = {1'b1, mant};
            sh     = 5'(-e - 10'sd1);
            hm24   = full >> sh;
            low24  = full & ((24'd1 << sh) - 24'd1);
            half24 = 24'd1 << (sh - 5'd1);
            if (low24 > half24 || (low24 == half24 && hm24[0])) hm24 = hm24 + 24'd1;
            r = {s, hm24[14:0]};
        end
        return r;
    endfunction

    // Round and pack: value = m / 2^26 * 2^(be - 127); m[0] carries sticky.
    // m[26] is the leading one, except at be == 1 where it may be clear.
    function automatic logic [31:0] fp_round(input logic s, input logic signed [10:0] be,
                                             input logic [26:0] m);
        logic [26:0]        mm;
        logic [7:0]         fld;
        logic signed [11:0] shs;
        logic [4:0]         sh;
        logic               lost;
        logic               rnd;
        logic [30:0]        body;
        shs = 12'sd1 - 12'(be);
        sh  = shs[4:0];
        if (be >= 11'sd255) begin
            return {s, 8'hFF, 23'd0};
        end
        if (be <= 11'sd0) begin
            if (shs >= 12'sd27) begin
                mm = {26'd0, |m};
            end else begin
                lost = |(m & ((27'd1 << sh) - 27'd1));
                mm   = (m >> sh) | {26'd0, lost};
            end
            fld = 8'd0;
        end else begin
            mm  = m;
            fld = m[26] ? be[7:0] : 8'd0;
        end
        rnd  = mm[2] & (mm[1] | mm[0] | mm[3]);
        body = {fld, mm[25:3]} + 31'(rnd);
        return {s, body};
    endfunction

    // Small unsigned count (nonzero) to fp32, exact
    function automatic logic [31:0] n_to_f32(input logic [LEN_W-1:0] n);
        logic [4:0]  p;
        logic [29:0] t;
        p = 5'd0;
        for (int i = 0; i < LEN_W; i++) begin
            if (n[i]) p = 5'(i);
        end
        t = 30'(n) << (5'd23 - p);
        return {1'b0, 8'(p) + 8'd127, t[22:0]};
    endfunction

endpackage

@@ rtl/rnc_buf.sv @@
// Element buffer: activation and gamma pairs, one synchronous write port and
// one synchronous read port with registered data. Uses rnc_pkg.
module rnc_buf
    import rnc_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0] mem_q [MAX_CHUNK];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_q[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_q[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/rnc_fmul.sv @@
// Pipelined fp32 multiplier: mantissa product, then round and pack.
// Operands are normal, zero, inf or NaN (never subnormal here). Uses rnc_pkg.
module rnc_fmul
    import rnc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  fp_req_t req,
    output fp_rsp_t rsp
);

    logic               v1_reg;
    logic               sp_reg;
    logic [31:0]        sp_val_reg;
    logic               sign_reg;
    logic signed [10:0] be_reg;
    logic [47:0]        prod_reg;
    logic               done_reg;
    logic [31:0]        res_reg;

    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s;
    logic        sp_next;
    logic [31:0] sp_val_next;

    always_comb
    begin
        a_nan  = f32_is_nan(req.a);
        b_nan  = f32_is_nan(req.b);
        a_inf  = f32_is_inf(req.a);
        b_inf  = f32_is_inf(req.b);
        a_zero = req.a[30:23] == 8'd0;
        b_zero = req.b[30:23] == 8'd0;
        s      = req.a[31] ^ req.b[31];
        sp_next     = 1'b1;
        sp_val_next = {s, 31'd0};
        if (a_nan)
            sp_val_next = req.a | F32_QBIT;
        else if (b_nan)
            sp_val_next = req.b | F32_QBIT;
        else if ((a_inf && b_zero) || (a_zero && b_inf))
            sp_val_next = F32_DNAN;
        else if (a_inf || b_inf)
            sp_val_next = {s, F32_PINF[30:0]};
        else if (a_zero || b_zero)
            sp_val_next = {s, 31'd0};
        else
            sp_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            sp_reg     <= sp_next;
            sp_val_reg <= sp_val_next;
            sign_reg   <= s;
            be_reg     <= $signed({3'b000, req.a[30:23]}) + $signed({3'b000, req.b[30:23]})
                          - 11'sd127;
            prod_reg   <= {1'b1, req.a[22:0]} * {1'b1, req.b[22:0]};
        end
        if (v1_reg)
        begin
            if (sp_reg)
                res_reg <= sp_val_reg;
            else if (prod_reg[47])
                res_reg <= fp_round(sign_reg, be_reg + 11'sd1,
                                    {prod_reg[47:22], |prod_reg[21:0]});
            else
                res_reg <= fp_round(sign_reg, be_reg, {prod_reg[46:21], |prod_reg[20:0]});
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

@@ rtl/rnc_fadd.sv @@
// Multi-cycle fp32 adder: align, add, normalize one bit a cycle, round.
// Uses rnc_pkg.
module rnc_fadd
    import rnc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  fp_req_t req,
    output fp_rsp_t rsp
);

    typedef enum logic [2:0] {
        FA_IDLE, FA_ALIGN, FA_ADD, FA_NORM, FA_ROUND
    } fa_state_t;

    fa_state_t          state_reg;
    logic [31:0]        a_reg, b_reg;
    logic [26:0]        ml_reg, ms_reg, m_reg;
    logic signed [10:0] exp_reg;
    logic               sign_reg, sub_reg;
    logic               done_reg;
    logic [31:0]        res_reg;

    logic        swap;
    logic [31:0] lg, sm;
    logic [7:0]  el, es, d;
    logic [26:0] mlg, msm, msh;
    logic [27:0] sum;
    logic        sp;
    logic [31:0] sp_val;

    always_comb
    begin
        swap = b_reg[30:0] > a_reg[30:0];
        lg   = swap ? b_reg : a_reg;
        sm   = swap ? a_reg : b_reg;
        el   = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
        es   = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
        d    = el - es;
        mlg  = {lg[30:23] != 8'd0, lg[22:0], 3'b000};
        msm  = {sm[30:23] != 8'd0, sm[22:0], 3'b000};
        if (d >= 8'd27)
            msh = {26'd0, |msm};
        else
            msh = (msm >> d) | {26'd0, |(msm & ((27'd1 << d) - 27'd1))};
        sp     = 1'b1;
        sp_val = F32_QNAN;
        if (f32_is_nan(a_reg) || f32_is_nan(b_reg))
            sp_val = F32_QNAN;
        else if (f32_is_inf(a_reg) && f32_is_inf(b_reg) && (a_reg[31] != b_reg[31]))
            sp_val = F32_DNAN;
        else if (f32_is_inf(a_reg))
            sp_val = a_reg;
        else if (f32_is_inf(b_reg))
            sp_val = b_reg;
        else
            sp = 1'b0;
        sum = sub_reg ? ({1'b0, ml_reg} - {1'b0, ms_reg}) : ({1'b0, ml_reg} + {1'b0, ms_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FA_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                FA_IDLE:
                begin
                    if (req.start)
                    begin
                        a_reg     <= req.a;
                        b_reg     <= req.b;
                        state_reg <= FA_ALIGN;
                    end
                end
                FA_ALIGN:
                begin
                    if (sp)
                    begin
                        res_reg   <= sp_val;
                        done_reg  <= 1'b1;
                        state_reg <= FA_IDLE;
                    end
                    else
                    begin
                        ml_reg    <= mlg;
                        ms_reg    <= msh;
                        exp_reg   <= $signed({3'b000, el});
                        sign_reg  <= lg[31];
                        sub_reg   <= lg[31] ^ sm[31];
                        state_reg <= FA_ADD;
                    end
                end
                FA_ADD:
                begin
                    if (sum == 28'd0)
                    begin
                        // exact cancellation gives +0; like-signed zeros keep sign
                        res_reg   <= {sub_reg ? 1'b0 : sign_reg, 31'd0};
                        done_reg  <= 1'b1;
                        state_reg <= FA_IDLE;
                    end
                    else if (sum[27])
                    begin
                        m_reg     <= {sum[27:2], sum[1] | sum[0]};
                        exp_reg   <= exp_reg + 11'sd1;
                        state_reg <= FA_NORM;
                    end
                    else
                    begin
                        m_reg     <= sum[26:0];
                        state_reg <= FA_NORM;
                    end
                end
                FA_NORM:
                begin
                    if (!m_reg[26] && exp_reg > 11'sd1)
                    begin
                        m_reg   <= {m_reg[25:0], 1'b0};
                        exp_reg <= exp_reg - 11'sd1;
                    end
                    else
                    begin
                        state_reg <= FA_ROUND;
                    end
                end
                FA_ROUND:
                begin
                    res_reg   <= fp_round(sign_reg, exp_reg, m_reg);
                    done_reg  <= 1'b1;
                    state_reg <= FA_IDLE;
                end
                default:
                begin
                    state_reg <= FA_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

@@ rtl/rnc_divsqrt.sv @@
// Shared bit-serial unit: fp32 divide (positive normal operands) or square
// root (positive finite nonzero operand), one result bit a cycle. Uses rnc_pkg.
module rnc_divsqrt
    import rnc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  ds_req_t req,
    output fp_rsp_t rsp
);

    typedef enum logic [1:0] {
        DS_IDLE, DS_NORM, DS_ITER, DS_FIN
    } ds_state_t;

    localparam logic [4:0] LAST_STEP = 5'd25;

    ds_state_t          state_reg;
    logic               op_reg;
    logic [23:0]        mb_reg;
    logic [24:0]        m_reg;
    logic [28:0]        rem_reg;
    logic [51:0]        acc_reg;
    logic [25:0]        q_reg;
    logic signed [10:0] e_reg;
    logic [4:0]         cnt_reg;
    logic               done_reg;
    logic [31:0]        res_reg;

    logic [23:0]        ma, mb;
    logic signed [10:0] be0;
    logic [28:0]        rem2, trial;
    logic [24:0]        m_adj;
    logic signed [10:0] be_fin;

    always_comb
    begin
        ma     = {1'b1, req.a[22:0]};
        mb     = {1'b1, req.b[22:0]};
        be0    = $signed({3'b000, req.a[30:23]}) - $signed({3'b000, req.b[30:23]}) + 11'sd127;
        rem2   = {rem_reg[26:0], acc_reg[51:50]};
        trial  = {1'b0, q_reg, 2'b01};
        m_adj  = e_reg[0] ? m_reg : {m_reg[23:0], 1'b0};
        be_fin = op_reg ? ((e_reg - 11'sd27) >>> 1) + 11'sd152 : e_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                DS_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg  <= req.op_sqrt;
                        q_reg   <= 26'd0;
                        cnt_reg <= 5'd0;
                        if (req.op_sqrt)
                        begin
                            m_reg     <= {1'b0, req.a[30:23] != 8'd0, req.a[22:0]};
                            e_reg     <= (req.a[30:23] == 8'd0) ? -11'sd149
                                         : $signed({3'b000, req.a[30:23]}) - 11'sd150;
                            state_reg <= DS_NORM;
                        end
                        else
                        begin
                            mb_reg <= mb;
                            if (ma < mb)
                            begin
                                rem_reg <= {4'd0, ma, 1'b0};
                                e_reg   <= be0 - 11'sd1;
                            end
                            else
                            begin
                                rem_reg <= {5'd0, ma};
                                e_reg   <= be0;
                            end
                            state_reg <= DS_ITER;
                        end
                    end
                end
                DS_NORM:
                begin
                    // subnormal radicand: shift up one bit a cycle
                    if (!m_reg[23])
                    begin
                        m_reg <= {m_reg[23:0], 1'b0};
                        e_reg <= e_reg - 11'sd1;
                    end
                    else
                    begin
                        acc_reg   <= {m_adj, 27'd0};
                        e_reg     <= e_reg[0] ? e_reg : e_reg - 11'sd1;
                        rem_reg   <= 29'd0;
                        state_reg <= DS_ITER;
                    end
                end
                DS_ITER:
                begin
                    if (op_reg)
                    begin
                        acc_reg <= {acc_reg[49:0], 2'b00};
                        if (rem2 >= trial)
                        begin
                            rem_reg <= rem2 - trial;
                            q_reg   <= {q_reg[24:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem2;
                            q_reg   <= {q_reg[24:0], 1'b0};
                        end
                    end
                    else
                    begin
                        if (rem_reg >= {5'd0, mb_reg})
                        begin
                            rem_reg <= {rem_reg[27:0] - {4'd0, mb_reg}, 1'b0};
                            q_reg   <= {q_reg[24:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[27:0], 1'b0};
                            q_reg   <= {q_reg[24:0], 1'b0};
                        end
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == LAST_STEP)
                        state_reg <= DS_FIN;
                end
                DS_FIN:
                begin
                    res_reg   <= fp_round(1'b0, be_fin, {q_reg, rem_reg != 29'd0});
                    done_reg  <= 1'b1;
                    state_reg <= DS_IDLE;
                end
                default:
                begin
                    state_reg <= DS_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

@@ rtl/rms_norm_chunked_core.sv @@
// Chunked RMS normalization core: top level.
// Depends on rnc_pkg, rnc_buf, rnc_fmul, rnc_fadd and rnc_divsqrt.
//
// Usage:
//  - Input channel (in_valid/in_ready, x_value, gamma_value): one fp16
//    activation and its fp16 gamma per transaction. Each element is written
//    to the buffer RAM and its square is added into an fp32 running sum.
//  - Once the buffer holds chunk_len elements (0 acts as 1, above 64 as 64),
//    the core computes r = 1/sqrt(sum/n + epsilon) and streams n results
//    on the output channel (out_valid/out_ready, y_value, last_of_chunk),
//    last_of_chunk high on the final one.
//  - Ingest: each element is squared in the multiplier, then added in the
//    multi-cycle adder. in_ready is low while an element is being
//    accumulated and during the whole chunk wrap-up.
//  - Chunk end: divide, add, square root (a subnormal argument is first
//    normalized bit by bit), reciprocal divide.
//  - Emission: each result takes a buffer read and two passes through the
//    shared multiplier; the next read starts once it is handed on.
//  - A registered output stage holds the result while out_ready is low; the
//    emission pass simply waits on it, nothing is dropped.
//  - Reset: chunk_len 64, epsilon 1e-6, sum and fill count cleared. The
//    buffer RAM is not cleared; entries are written before they are read.
//  - Config writes (cfg_we, cfg_index, cfg_data) take effect at once and are
//    only meant while the core is idle.
module rms_norm_chunked_core
    import rnc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [15:0]      x_value,
    input  logic [15:0]      gamma_value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      y_value,
    output logic             last_of_chunk
);

    typedef enum logic [3:0] {
        S_IN,      // waiting for an element
        S_SQ,      // square in the multiplier
        S_ACC,     // add square into running sum
        S_MEAN,    // start sum / n
        S_MEANW,
        S_EPS,     // start mean + epsilon
        S_ARG,
        S_ROOT,    // classify argument, start sqrt
        S_ROOTW,
        S_RECW,    // reciprocal divide
        S_RD,      // buffer read
        S_M1,      // x * gamma
        S_M1W,
        S_M2W,     // (x * gamma) * r
        S_OUT      // hand to output stage
    } state_t;

    state_t           state_reg;
    logic [LEN_W-1:0] chunk_len_reg;
    logic [31:0]      eps_reg;
    logic [31:0]      sum_reg;
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] k_reg;
    logic [31:0]      mean_reg;
    logic [31:0]      arg_reg;
    logic [31:0]      r_reg;
    logic             out_valid_reg;
    logic [15:0]      y_reg;
    logic             last_reg;

    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] fill_next;
    logic             in_acc;
    logic             sum_special;
    logic             arg_plain;
    logic             out_free;
    logic             last_k;
    logic [31:0]      rd_data;

    fp_req_t mul_req, add_req;
    fp_rsp_t mul_rsp, add_rsp, ds_rsp;
    ds_req_t ds_req;

    // effective chunk length
    always_comb
    begin
        if (chunk_len_reg == '0)
            len_eff = LEN_W'(1);
        else if (chunk_len_reg > LEN_W'(MAX_CHUNK))
            len_eff = LEN_W'(MAX_CHUNK);
        else
            len_eff = chunk_len_reg;
    end

    assign in_ready    = (state_reg == S_IN);
    assign in_acc      = in_valid && in_ready;
    assign fill_next   = fill_reg + LEN_W'(1);
    assign sum_special = (sum_reg[30:23] == 8'hFF) || f32_is_zero(sum_reg);
    assign arg_plain   = !arg_reg[31] && !f32_is_zero(arg_reg) && (arg_reg[30:23] != 8'hFF);
    assign out_free    = !out_valid_reg || out_ready;
    assign last_k      = (k_reg + LEN_W'(1)) == fill_reg;

    // shared multiplier: squares on ingest, x*gamma and *r on emission
    always_comb
    begin
        mul_req.start = (state_reg == S_IN && in_valid) || (state_reg == S_M1)
                        || (state_reg == S_M1W && mul_rsp.done);
        case (state_reg)
            S_IN:
            begin
                mul_req.a = h2f(x_value);
                mul_req.b = h2f(x_value);
            end
            S_M1:
            begin
                mul_req.a = h2f(rd_data[31:16]);
                mul_req.b = h2f(rd_data[15:0]);
            end
            default:
            begin
                mul_req.a = mul_rsp.value;
                mul_req.b = r_reg;
            end
        endcase
    end

    always_comb
    begin
        add_req.start = (state_reg == S_SQ && mul_rsp.done) || (state_reg == S_EPS);
        add_req.a     = (state_reg == S_SQ) ? sum_reg : mean_reg;
        add_req.b     = (state_reg == S_SQ) ? mul_rsp.value : eps_reg;
    end

    always_comb
    begin
        ds_req.start   = (state_reg == S_MEAN && !sum_special)
                         || (state_reg == S_ROOT && arg_plain)
                         || (state_reg == S_ROOTW && ds_rsp.done);
        ds_req.op_sqrt = (state_reg == S_ROOT);
        case (state_reg)
            S_MEAN:
            begin
                ds_req.a = sum_reg;
                ds_req.b = n_to_f32(fill_reg);
            end
            S_ROOT:
            begin
                ds_req.a = arg_reg;
                ds_req.b = F32_ONE;
            end
            default:
            begin
                ds_req.a = F32_ONE;
                ds_req.b = ds_rsp.value;
            end
        endcase
    end

    rnc_buf u_buf (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data ({x_value, gamma_value}),
        .rd_en   (state_reg == S_RD),
        .rd_addr (k_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    rnc_fmul u_fmul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    rnc_fadd u_fadd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (add_req),
        .rsp   (add_rsp)
    );

    rnc_divsqrt u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ds_req),
        .rsp   (ds_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IN;
            chunk_len_reg <= CHUNK_LEN_RST;
            eps_reg       <= EPS_RST;
            sum_reg       <= 32'd0;
            fill_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CHUNK_LEN: chunk_len_reg <= cfg_data[LEN_W-1:0];
                    CFG_EPSILON:   eps_reg       <= cfg_data[31:0];
                    default:       ;
                endcase
            end

            // output stage: load a new result, or drop once taken
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IN:
                begin
                    if (in_valid)
                        state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (mul_rsp.done)
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (add_rsp.done)
                    begin
                        sum_reg  <= add_rsp.value;
                        fill_reg <= fill_next;
                        state_reg <= (fill_next >= len_eff) ? S_MEAN : S_IN;
                    end
                end
                S_MEAN:
                begin
                    // zero, inf and NaN sums pass straight through the divide
                    if (sum_special)
                    begin
                        mean_reg  <= sum_reg;
                        state_reg <= S_EPS;
                    end
                    else
                    begin
                        state_reg <= S_MEANW;
                    end
                end
                S_MEANW:
                begin
                    if (ds_rsp.done)
                    begin
                        mean_reg  <= ds_rsp.value;
                        state_reg <= S_EPS;
                    end
                end
                S_EPS:
                begin
                    state_reg <= S_ARG;
                end
                S_ARG:
                begin
                    if (add_rsp.done)
                    begin
                        arg_reg   <= add_rsp.value;
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    k_reg <= '0;
                    if (arg_plain)
                        state_reg <= S_ROOTW;
                    else
                    begin
                        // zero root gives +inf; NaN or negative gives NaN;
                        // infinite root gives +0
                        if (f32_is_nan(arg_reg))
                            r_reg <= F32_QNAN;
                        else if (f32_is_zero(arg_reg))
                            r_reg <= F32_PINF;
                        else if (arg_reg[31])
                            r_reg <= F32_QNAN;
                        else
                            r_reg <= 32'd0;
                        state_reg <= S_RD;
                    end
                end
                S_ROOTW:
                begin
                    if (ds_rsp.done)
                        state_reg <= S_RECW;
                end
                S_RECW:
                begin
                    if (ds_rsp.done)
                    begin
                        r_reg     <= ds_rsp.value;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    state_reg <= S_M1W;
                end
                S_M1W:
                begin
                    if (mul_rsp.done)
                        state_reg <= S_M2W;
                end
                S_M2W:
                begin
                    if (mul_rsp.done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        y_reg         <= f2h(mul_rsp.value);
                        last_reg      <= last_k;
                        if (last_k)
                        begin
                            sum_reg   <= 32'd0;
                            fill_reg  <= '0;
                            state_reg <= S_IN;
                        end
                        else
                        begin
                            k_reg     <= k_reg + LEN_W'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IN;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign y_value       = y_reg;
    assign last_of_chunk = last_reg;

endmodule
